@@ hw/rtl/icd_pkg.sv @@
package icd_pkg;

   // number of identifier characters that feed the check digit
   localparam int unsigned NumChars = 11;

   // ascii codes used for classification
   localparam logic [7:0] AsciiZero  = 8'h30;
   localparam logic [7:0] AsciiNine  = 8'h39;
   localparam logic [7:0] AsciiUpA   = 8'h41;
   localparam logic [7:0] AsciiUpZ   = 8'h5A;

   // letters expand to the values 10 .. 35
   localparam logic [5:0] LetterBase = 6'd10;

   // per-character terms, each already reduced mod 10
   typedef struct packed {
      logic [3:0] term_dbl;   // term when the rightmost digit of the char is doubled
      logic [3:0] term_pln;   // term when it is not
      logic       flip;       // char expands to one digit, so the weight toggles
      logic       bad;        // not an uppercase letter or a decimal digit
   } char_term_type;

   // digit sum of a doubled decimal digit
   function automatic logic [3:0] dbl_digit_sum(input logic [3:0] d);
      logic [4:0] two_d;
      two_d = {d, 1'b0};
      if (two_d >= 5'd10) begin
         dbl_digit_sum = 4'(two_d - 5'd9);
      end else begin
         dbl_digit_sum = two_d[3:0];
      end
   endfunction

   // reduce a value below 20 modulo 10
   function automatic logic [3:0] mod10_small(input logic [4:0] v);
      if (v >= 5'd10) begin
         mod10_small = 4'(v - 5'd10);
      end else begin
         mod10_small = v[3:0];
      end
   endfunction

   // classify one ascii byte and give both possible luhn terms
   function automatic char_term_type char_term(input logic [7:0] ch);
      char_term_type t;
      logic [5:0]    val;
      logic [3:0]    lo;
      logic [1:0]    hi;
      t   = '{term_dbl: 4'd0, term_pln: 4'd0, flip: 1'b0, bad: 1'b0};
      val = '0;
      lo  = '0;
      hi  = '0;
      if (ch >= AsciiZero && ch <= AsciiNine) begin
         lo         = 4'(ch - AsciiZero);
         t.term_dbl = dbl_digit_sum(lo);
         t.term_pln = lo;
         t.flip     = 1'b1;
      end else if (ch >= AsciiUpA && ch <= AsciiUpZ) begin
         val = 6'(ch - AsciiUpA) + LetterBase;
         // split into tens and units by compare
         if (val >= 6'd30) begin
            hi = 2'd3;
            lo = 4'(val - 6'd30);
         end else if (val >= 6'd20) begin
            hi = 2'd2;
            lo = 4'(val - 6'd20);
         end else begin
            hi = 2'd1;
            lo = 4'(val - 6'd10);
         end
         // low digit takes the current weight, high digit the other one
         t.term_dbl = mod10_small(5'(dbl_digit_sum(lo)) + 5'(hi));
         t.term_pln = mod10_small(5'(lo) + 5'({hi, 1'b0}));
      end else begin
         t.bad = 1'b1;
      end
      char_term = t;
   endfunction

   // remainder mod 10 of a sum of eleven terms (at most 99)
   function automatic logic [3:0] mod10_sum(input logic [6:0] s);
      logic [3:0] tens;
      tens = '0;
      for (int k = 1; k <= 9; k++) begin
         if (s >= 7'(10 * k)) begin
            tens = 4'(k);
         end
      end
      mod10_sum = 4'(s - 7'(10 * tens));
   endfunction

endpackage

@@ hw/rtl/isin_check_digit.sv @@
// isin check digit generator
//
// req channel: one beat carries the eleven ascii bytes of an identifier
// prefix (req_symbol_0 is the first country letter, req_symbol_10 the
// rightmost character). rsp channel: one beat per request with the check
// digit and an invalid flag; invalid is set, and the digit forced to 0,
// when any byte is not an uppercase letter or a decimal digit.
//
// a request passes through registered stages to the response: stage one
// classifies each byte and forms its two possible luhn terms, stage two
// resolves the doubling pattern and forms three partial sums, stage
// three adds them, reduces mod 10 and holds the response beat. one beat
// per cycle while rsp_ready is high; every stage carries its own valid bit.
//
// when rsp_ready is low the stages fill up one by one, and req_ready falls
// only once all three hold a beat; nothing is dropped or repeated.
// reset (synchronous, active high) clears the valid bits and so discards
// any beats in flight.
module isin_check_digit (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_symbol_0,
   input  logic [7:0] req_symbol_1,
   input  logic [7:0] req_symbol_2,
   input  logic [7:0] req_symbol_3,
   input  logic [7:0] req_symbol_4,
   input  logic [7:0] req_symbol_5,
   input  logic [7:0] req_symbol_6,
   input  logic [7:0] req_symbol_7,
   input  logic [7:0] req_symbol_8,
   input  logic [7:0] req_symbol_9,
   input  logic [7:0] req_symbol_10,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [3:0] rsp_check_digit,
   output logic       rsp_invalid
);

   localparam int unsigned NChars = icd_pkg::NumChars;

   logic [7:0] symbols [NChars];

   // stage one: per-character terms
   logic                  s1_valid_ff, s1_valid_in;
   icd_pkg::char_term_type s1_term_ff [NChars];
   // stage two: partial sums
   logic                  s2_valid_ff, s2_valid_in;
   logic [5:0]            s2_sum_a_ff, s2_sum_b_ff, s2_sum_c_ff;
   logic [5:0]            s2_sum_a_in, s2_sum_b_in, s2_sum_c_in;
   logic                  s2_bad_ff, s2_bad_in;
   // stage three: response register
   logic                  s3_valid_ff, s3_valid_in;
   logic [3:0]            s3_digit_ff, s3_digit_in;
   logic                  s3_bad_ff;

   logic                  s1_ready, s2_ready, s3_ready;
   logic [NChars-1:0]     dbl_sel;
   logic [3:0]            sel_term [NChars];
   logic [6:0]            total;
   logic [3:0]            rem;

   assign symbols[0]  = req_symbol_0;
   assign symbols[1]  = req_symbol_1;
   assign symbols[2]  = req_symbol_2;
   assign symbols[3]  = req_symbol_3;
   assign symbols[4]  = req_symbol_4;
   assign symbols[5]  = req_symbol_5;
   assign symbols[6]  = req_symbol_6;
   assign symbols[7]  = req_symbol_7;
   assign symbols[8]  = req_symbol_8;
   assign symbols[9]  = req_symbol_9;
   assign symbols[10] = req_symbol_10;

   // stall chain: a stage advances when it is empty or its successor moves
   assign s3_ready  = !s3_valid_ff || rsp_ready;
   assign s2_ready  = !s2_valid_ff || s3_ready;
   assign s1_ready  = !s1_valid_ff || s2_ready;
   assign req_ready = s1_ready;

   assign s1_valid_in = s1_ready ? req_valid : s1_valid_ff;
   assign s2_valid_in = s2_ready ? s1_valid_ff : s2_valid_ff;
   assign s3_valid_in = s3_ready ? s2_valid_ff : s3_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
         s3_valid_ff <= s3_valid_in;
      end
   end

   // stage one payload: classify each byte
   always_ff @(posedge clock) begin
      if (s1_ready) begin
         for (int i = 0; i < NChars; i++) begin
            s1_term_ff[i] <= icd_pkg::char_term(symbols[i]);
         end
      end
   end

   // doubling pattern: the rightmost digit is doubled, each single-digit
   // char to the right toggles the weight, letters and bad bytes keep it
   always_comb begin
      dbl_sel[NChars-1] = 1'b1;
      for (int i = NChars - 2; i >= 0; i--) begin
         dbl_sel[i] = dbl_sel[i+1] ^ s1_term_ff[i+1].flip;
      end
   end

   // pick the term per char and form three partial sums
   always_comb begin
      s2_bad_in   = 1'b0;
      s2_sum_a_in = '0;
      s2_sum_b_in = '0;
      s2_sum_c_in = '0;
      for (int i = 0; i < NChars; i++) begin
         sel_term[i] = dbl_sel[i] ? s1_term_ff[i].term_dbl : s1_term_ff[i].term_pln;
         s2_bad_in   = s2_bad_in | s1_term_ff[i].bad;
      end
      for (int i = 0; i < 4; i++) begin
         s2_sum_a_in = s2_sum_a_in + 6'(sel_term[i]);
         s2_sum_b_in = s2_sum_b_in + 6'(sel_term[i+4]);
      end
      for (int i = 8; i < NChars; i++) begin
         s2_sum_c_in = s2_sum_c_in + 6'(sel_term[i]);
      end
   end

   always_ff @(posedge clock) begin
      if (s2_ready) begin
         s2_sum_a_ff <= s2_sum_a_in;
         s2_sum_b_ff <= s2_sum_b_in;
         s2_sum_c_ff <= s2_sum_c_in;
         s2_bad_ff   <= s2_bad_in;
      end
   end

   // final sum, reduction mod 10 and check digit
   assign total = 7'(s2_sum_a_ff) + 7'(s2_sum_b_ff) + 7'(s2_sum_c_ff);
   assign rem   = icd_pkg::mod10_sum(total);

   always_comb begin
      if (s2_bad_ff || rem == 4'd0) begin
         s3_digit_in = 4'd0;
      end else begin
         s3_digit_in = 4'd10 - rem;
      end
   end

   always_ff @(posedge clock) begin
      if (s3_ready) begin
         s3_digit_ff <= s3_digit_in;
         s3_bad_ff   <= s2_bad_ff;
      end
   end

   assign rsp_valid       = s3_valid_ff;
   assign rsp_check_digit = s3_digit_ff;
   assign rsp_invalid     = s3_bad_ff;

   // an invalid beat never carries a non-zero digit
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_invalid) |-> (rsp_check_digit == 4'd0))
      else $error("invalid response with non-zero check digit");

   // the check digit is always a decimal digit
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_check_digit <= 4'd9))
      else $error("check digit out of range");

   // requests are refused only when every stage holds a beat
   assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> (s1_valid_ff && s2_valid_ff && s3_valid_ff))
      else $error("request stalled with an empty stage");

   // with no backpressure an accepted beat passes stage one, two and three to the output
   assert property (@(posedge clock) disable iff (reset)
      ($past(req_valid && req_ready, 3) && !$past(reset, 3) && !$past(reset, 2)
       && !$past(reset, 1) && $past(rsp_ready, 2) && $past(rsp_ready, 1))
      |-> rsp_valid)
      else $error("response beat missing after unstalled latency");

endmodule

@@ verif/isin_check_digit_test.sv @@
`timescale 1ns / 100ps

module isin_check_digit_test;

   // eleven ascii bytes of one identifier prefix, index 0 is the first country letter
   typedef logic [icd_pkg::NumChars-1:0][7:0] prefix_type;

   typedef struct packed {
      logic [3:0] check_digit;
      logic       invalid;
   } check_result_type;

   localparam int unsigned CycleLimit = 400000;
   localparam int unsigned RandomItems = 1700;
   localparam int unsigned DrainCycles = 8;
   localparam int unsigned MaxGap = 18;

   // expected check digits of accepted identifiers, oldest first
   class check_digit_board;
      check_result_type digit_q[$];
      int unsigned      mismatches;

      function new();
         mismatches = 0;
      endfunction

      function int unsigned digit_sum(int unsigned x);
         return (x % 10) + (x / 10);
      endfunction

      // luhn over the expanded digit string, rightmost digit doubled
      function check_result_type luhn_check(prefix_type s);
         int unsigned      total;
         int unsigned      v;
         bit               dbl;
         bit               bad;
         check_result_type r;
         total = 0;
         dbl   = 1'b1;
         bad   = 1'b0;
         for (int p = icd_pkg::NumChars - 1; p >= 0; p--) begin
            if (s[p] >= icd_pkg::AsciiZero && s[p] <= icd_pkg::AsciiNine) begin
               v = 32'(s[p] - icd_pkg::AsciiZero);
               total += digit_sum(dbl ? 2 * v : v);
               dbl = !dbl;
            end else if (s[p] >= icd_pkg::AsciiUpA && s[p] <= icd_pkg::AsciiUpZ) begin
               // two digits, so the weight for the next char is unchanged
               v = 32'(s[p] - icd_pkg::AsciiUpA) + 10;
               total += digit_sum(dbl ? 2 * (v % 10) : v % 10);
               total += digit_sum(dbl ? v / 10 : 2 * (v / 10));
            end else begin
               bad = 1'b1;
            end
         end
         r.invalid     = bad;
         r.check_digit = bad ? 4'd0 : 4'((10 - total % 10) % 10);
         return r;
      endfunction

      function void note_request(prefix_type s);
         digit_q.insert(digit_q.size(), luhn_check(s));
      endfunction

      function int unsigned pending();
         return digit_q.size();
      endfunction

      task report(string msg);
         mismatches++;
         $display("mismatch at %0t: %s", $realtime, msg);
      endtask

      task check_response(logic [3:0] digit, logic inv);
         check_result_type exp_r;
         if (digit_q.size() == 0) begin
            report($sformatf("response beat with no request waiting (digit %0d invalid %0b)",
                             digit, inv));
         end else begin
            exp_r = digit_q.pop_front();
            if (digit !== exp_r.check_digit) begin
               report($sformatf("check_digit %0d, expected %0d", digit, exp_r.check_digit));
            end
            if (inv !== exp_r.invalid) begin
               report($sformatf("invalid %0b, expected %0b", inv, exp_r.invalid));
            end
         end
      endtask
   endclass

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_ready;
   prefix_type req_symbols = '0;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   logic [3:0] rsp_check_digit;
   logic       rsp_invalid;

   check_digit_board board = new();
   int unsigned      cycle_count = 0;
   bit               steady = 1'b0;

   isin_check_digit uut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_symbol_0    (req_symbols[0]),
      .req_symbol_1    (req_symbols[1]),
      .req_symbol_2    (req_symbols[2]),
      .req_symbol_3    (req_symbols[3]),
      .req_symbol_4    (req_symbols[4]),
      .req_symbol_5    (req_symbols[5]),
      .req_symbol_6    (req_symbols[6]),
      .req_symbol_7    (req_symbols[7]),
      .req_symbol_8    (req_symbols[8]),
      .req_symbol_9    (req_symbols[9]),
      .req_symbol_10   (req_symbols[10]),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_check_digit (rsp_check_digit),
      .rsp_invalid     (rsp_invalid)
   );

   always #5 clock = ~clock;

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CycleLimit) begin
         $display("Some tests failed");
         $finish;
      end
   end

   // watch both channels for accepted beats
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) begin
            board.note_request(req_symbols);
         end
         if (rsp_valid && rsp_ready) begin
            board.check_response(rsp_check_digit, rsp_invalid);
         end
      end
   end

   function automatic int unsigned draw_gap();
      return steady ? 0 : $urandom_range(0, MaxGap);
   endfunction

   function automatic prefix_type from_text(string t);
      prefix_type s;
      for (int p = 0; p < icd_pkg::NumChars; p++) begin
         s[p] = t[p];
      end
      return s;
   endfunction

   // mostly well-formed prefixes, some with stray bytes, a few pure noise
   function automatic prefix_type random_prefix();
      prefix_type  s;
      int unsigned kind;
      int unsigned v;
      kind = $urandom_range(0, 9);
      for (int p = 0; p < icd_pkg::NumChars; p++) begin
         v = (p < 2) ? $urandom_range(10, 35) : $urandom_range(0, 35);
         s[p] = (v < 10) ? 8'(icd_pkg::AsciiZero + v) : 8'(icd_pkg::AsciiUpA + v - 10);
      end
      if (kind == 8) begin
         repeat ($urandom_range(1, 3)) begin
            s[$urandom_range(0, icd_pkg::NumChars - 1)] = 8'($urandom_range(0, 255));
         end
      end else if (kind == 9) begin
         for (int p = 0; p < icd_pkg::NumChars; p++) begin
            s[p] = 8'($urandom_range(0, 255));
         end
      end
      return s;
   endfunction

   // present one request beat and hold it until accepted
   task automatic send_prefix(prefix_type s);
      int unsigned gap;
      gap = draw_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_symbols <= s;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   // hold off the sender until every response beat is back
   task automatic drain_responses();
      req_valid <= 1'b0;
      @(posedge clock);
      while (board.pending() != 0) @(posedge clock);
   endtask

   // response side: random stalls between beats
   initial begin
      int unsigned gap;
      while (reset) @(posedge clock);
      forever begin
         gap = draw_gap();
         if (gap > 0) begin
            rsp_ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
      end
   end

   initial begin
      logic [7:0] bad_bytes [icd_pkg::NumChars];
      prefix_type s;
      bad_bytes = '{8'h00, 8'hFF, 8'h2F, 8'h3A, 8'h40, 8'h5B,
                    8'h60, 8'h7B, 8'h80, 8'h7F, 8'h61};
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // directed: known code, extremes of both character classes
      send_prefix(from_text("US037833100"));
      send_prefix(from_text("AAAAAAAAAAA"));
      send_prefix(from_text("ZZZZZZZZZZZ"));
      send_prefix(from_text("00000000000"));
      send_prefix(from_text("99999999999"));
      send_prefix(from_text("AZ09AZ09AZ0"));
      send_prefix(from_text("ZA90ZA90ZA9"));
      send_prefix(from_text("GB000263494"));
      send_prefix(from_text("uS037833100"));
      // one bad byte at each position, the country letters included
      for (int p = 0; p < icd_pkg::NumChars; p++) begin
         s = from_text("US037833100");
         s[p] = bad_bytes[p];
         send_prefix(s);
      end
      send_prefix('1);
      send_prefix('0);
      drain_responses();

      // random part in phases, some with no idling at all
      for (int i = 0; i < RandomItems; i++) begin
         if (i % 200 == 0) begin
            steady = ((i / 200) % 3 == 1);
         end
         if (i == RandomItems / 2) begin
            drain_responses();
         end
         send_prefix(random_prefix());
      end
      drain_responses();
      repeat (DrainCycles) @(posedge clock);

      if (board.mismatches == 0 && board.pending() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
